@@ sv/rmc_position_extractor_defines.svh @@
// ----------------------------------------------------------------------------
// RMC position extractor assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RMC_POSITION_EXTRACTOR_DEFINES_SVH
`define RMC_POSITION_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds in the same cycle.
`define RMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define RMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMC_ASSERT(lbl, prop, msg)
`define RMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/rmc_pkg.sv @@
// ----------------------------------------------------------------------------
// RMC position extractor package
// Shared types, character codes and widths for the sentence parser.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 4;
    localparam int SKIP_W  = 5;
    localparam int POS_W   = 5;

    localparam logic [SKIP_W-1:0] SKIP_RESET = 5'd12;
    localparam logic [POS_W-1:0]  HDR_LAST   = 5'd4;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
    localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h52;
    localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_V      = 8'h56;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_HEADER,
        PH_SKIP,
        PH_STATUS,
        PH_GAP1,
        PH_LAT,
        PH_GAP2,
        PH_HEMI,
        PH_GAP3,
        PH_LON
    } phase_t;

    // One completed sentence waiting for the emitter.
    typedef struct packed {
        logic bank;
        logic fix_valid;
    } token_t;

    function automatic logic [CHAR_W-1:0] hdr_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            5'd0:    ch = CH_G;
            5'd1:    ch = CH_P;
            5'd2:    ch = CH_R;
            5'd3:    ch = CH_M;
            5'd4:    ch = CH_C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ sv/rmc_front.sv @@
// ----------------------------------------------------------------------------
// RMC front end
// Parses incoming bytes, writes captured coordinate bytes into the store bank
// being filled and queues a token when a sentence completes.
// ----------------------------------------------------------------------------
module rmc_front
    import rmc_pkg::*;
#(
    parameter  int LAT_CHARS = 9,
    parameter  int LON_CHARS = 10,
    localparam int DEPTH     = LAT_CHARS + LON_CHARS,
    localparam int IDX_W     = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SKIP_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] rx_byte,
    input  logic              q_full,
    output logic              push,
    output token_t            push_token,
    output logic              wr_en,
    output logic [IDX_W:0]    wr_addr,
    output logic [CHAR_W-1:0] wr_data
);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic               status_reg, status_next;
    logic               bank_reg, bank_next;
    logic               accept;
    logic [POS_W-1:0]   pos_inc;
    logic [IDX_W-1:0]   wr_idx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pos_inc  = pos_reg + 1'b1;

    assign skip_next = cfg_wr_en ? cfg_wr_data : skip_reg;
    assign bank_next = bank_reg ^ push;

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (pos_reg <= HDR_LAST && rx_byte == hdr_char(pos_reg))
                    begin
                        pos_next = pos_inc;
                        if (pos_reg == HDR_LAST)
                        begin
                            pos_next   = '0;
                            phase_next = (skip_reg == '0) ? PH_STATUS : PH_SKIP;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= skip_reg)
                        phase_next = PH_STATUS;
                end
                PH_STATUS:
                begin
                    if (rx_byte == CH_A || rx_byte == CH_V)
                    begin
                        status_next = (rx_byte == CH_A);
                        phase_next  = PH_GAP1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_GAP1:
                begin
                    pos_next   = '0;
                    phase_next = PH_LAT;
                end
                PH_LAT:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= POS_W'(LAT_CHARS))
                        phase_next = PH_GAP2;
                end
                PH_GAP2:
                begin
                    phase_next = PH_HEMI;
                end
                PH_HEMI:
                begin
                    phase_next = (rx_byte == CH_N) ? PH_GAP3 : PH_HUNT;
                end
                PH_GAP3:
                begin
                    pos_next   = '0;
                    phase_next = PH_LON;
                end
                PH_LON:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= POS_W'(LON_CHARS))
                    begin
                        pos_next   = '0;
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Outputs: store writes and sentence tokens
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = '0;
        push   = 1'b0;
        case (phase_reg)
            PH_LAT:
            begin
                wr_en  = accept && (pos_reg < POS_W'(LAT_CHARS));
                wr_idx = IDX_W'(pos_reg);
            end
            PH_LON:
            begin
                wr_en  = accept && (pos_reg < POS_W'(LON_CHARS));
                wr_idx = IDX_W'(POS_W'(LAT_CHARS) + pos_reg);
                push   = accept && (pos_inc >= POS_W'(LON_CHARS));
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign wr_addr              = {bank_reg, wr_idx};
    assign wr_data              = rx_byte;
    assign push_token.bank      = bank_reg;
    assign push_token.fix_valid = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            skip_reg   <= SKIP_RESET;
            status_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            status_reg <= status_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

@@ sv/rmc_fifo.sv @@
// ----------------------------------------------------------------------------
// RMC token queue
// Two-entry queue of completed sentences between the parser and the emitter.
// ----------------------------------------------------------------------------
`include "rmc_position_extractor_defines.svh"

module rmc_fifo
    import rmc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    input  logic   pop,
    output logic   full,
    output logic   tok_valid,
    output token_t tok
);

    token_t      entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        empty;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign tok_valid = !empty;
    assign tok       = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg ^ push;
    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RMC_ASSERT(a_no_overflow, !(push && full), "token pushed into full queue")
    `RMC_ASSERT(a_no_underflow, !(pop && empty), "token popped from empty queue")
    `RMC_ASSERT_NEXT(a_push_seen, push && !pop, !empty, "pushed token missing")

endmodule

@@ sv/rmc_back.sv @@
// ----------------------------------------------------------------------------
// RMC back end
// Holds the two-bank coordinate store and plays out one stored sentence per
// token via the registered read port, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "rmc_position_extractor_defines.svh"

module rmc_back
    import rmc_pkg::*;
#(
    parameter  int LAT_CHARS = 9,
    parameter  int LON_CHARS = 10,
    localparam int DEPTH     = LAT_CHARS + LON_CHARS,
    localparam int IDX_W     = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W:0]     wr_addr,
    input  logic [CHAR_W-1:0]  wr_data,
    input  logic               tok_valid,
    input  token_t             tok,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  coord_char,
    output logic               is_longitude,
    output logic [INDEX_W-1:0] char_index,
    output logic               fix_valid,
    output logic               last
);

    logic [CHAR_W-1:0]  mem [2**(IDX_W+1)];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic               lon_reg, lon_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               fix_reg, fix_next;
    logic               last_reg, last_next;
    logic               issue;
    logic               k_last;

    // Read the next character when a token waits and the output slot is free next cycle.
    assign issue  = tok_valid && (!out_valid_reg || out_ready);
    assign k_last = (k_reg == IDX_W'(DEPTH - 1));
    assign pop    = issue && k_last;

    always_comb
    begin
        k_next = k_reg;
        if (pop)
            k_next = '0;
        else if (issue)
            k_next = k_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign lon_next  = (k_reg >= IDX_W'(LAT_CHARS));
    assign idx_next  = lon_next ? INDEX_W'(k_reg - IDX_W'(LAT_CHARS)) : INDEX_W'(k_reg);
    assign fix_next  = tok.fix_valid;
    assign last_next = k_last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[{tok.bank, k_reg}];
            lon_reg     <= lon_next;
            idx_reg     <= idx_next;
            fix_reg     <= fix_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coord_char   = rd_data_reg;
    assign is_longitude = lon_reg;
    assign char_index   = idx_reg;
    assign fix_valid    = fix_reg;
    assign last         = last_reg;

    `RMC_ASSERT(a_idx_range, !out_valid_reg || (!lon_reg && int'(idx_reg) < LAT_CHARS) || (lon_reg && int'(idx_reg) < LON_CHARS), "character index out of field range")
    `RMC_ASSERT(a_last_pos, !(out_valid_reg && last_reg) || (lon_reg && int'(idx_reg) == LON_CHARS - 1), "last marker not on final longitude character")
    `RMC_ASSERT_NEXT(a_run_restart, out_valid_reg && out_ready && last_reg, !out_valid_reg || (!lon_reg && idx_reg == '0), "run did not restart at first latitude character")

endmodule

@@ sv/rmc_position_extractor.sv @@
// ----------------------------------------------------------------------------
// RMC position extractor
// Pulls latitude and longitude text out of RMC sentences in a byte stream
// and emits each completed sentence as a run of coordinate characters.
//
//   Channel  Handshake                Payload
//   in       in_valid / in_ready      rx_byte
//   out      out_valid / out_ready    coord_char, is_longitude, char_index,
//                                     fix_valid, last
//   cfg      cfg_wr_en                cfg_wr_data (skip_count)
//
// One byte is accepted per cycle while in_ready is high. A completed
// sentence is played out from a two-bank store, one character per cycle
// while out_ready is high, LAT_CHARS+LON_CHARS characters per run.
// in_ready drops only while two completed sentences wait in the token queue.
// Reset is asynchronous: parser hunts for '$', skip_count returns to 12.
// ----------------------------------------------------------------------------
module rmc_position_extractor
    import rmc_pkg::*;
#(
    parameter int LAT_CHARS = 9,
    parameter int LON_CHARS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [SKIP_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  coord_char,
    output logic               is_longitude,
    output logic [INDEX_W-1:0] char_index,
    output logic               fix_valid,
    output logic               last
);

    localparam int DEPTH = LAT_CHARS + LON_CHARS;
    localparam int IDX_W = $clog2(DEPTH);

    logic              push;
    token_t            push_token;
    logic              pop;
    logic              q_full;
    logic              tok_valid;
    token_t            tok;
    logic              wr_en;
    logic [IDX_W:0]    wr_addr;
    logic [CHAR_W-1:0] wr_data;

    rmc_front #(
        .LAT_CHARS (LAT_CHARS),
        .LON_CHARS (LON_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .push        (push),
        .push_token  (push_token),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    rmc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (q_full),
        .tok_valid  (tok_valid),
        .tok        (tok)
    );

    rmc_back #(
        .LAT_CHARS (LAT_CHARS),
        .LON_CHARS (LON_CHARS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coord_char   (coord_char),
        .is_longitude (is_longitude),
        .char_index   (char_index),
        .fix_valid    (fix_valid),
        .last         (last)
    );

endmodule

@@ dv/tb_rmc_position_extractor.sv @@
// ----------------------------------------------------------------------------
// RMC position extractor testbench
// Drives byte streams of well-formed, broken and noisy RMC sentences into the
// parser. A parser model built into the bench predicts each coordinate run,
// and every output transaction is checked field by field. Runs under several
// skip counts and several mixes of input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_rmc_position_extractor;
    import rmc_pkg::*;

    localparam int LAT_CHARS     = 9;
    localparam int LON_CHARS     = 10;
    localparam int RUN_CHARS     = LAT_CHARS + LON_CHARS;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;

    localparam logic [5*CHAR_W-1:0] HDR_TEXT = {CH_G, CH_P, CH_R, CH_M, CH_C};

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               lon;
        logic [INDEX_W-1:0] idx;
        logic               fix;
        logic               last;
    } coord_rec_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [SKIP_W-1:0]  cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [CHAR_W-1:0]  rx_byte;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  coord_char;
    logic               is_longitude;
    logic [INDEX_W-1:0] char_index;
    logic               fix_valid;
    logic               last;

    // Parser model state
    phase_t            parse_ph;
    logic [POS_W-1:0]  parse_pos;
    logic [SKIP_W-1:0] skip_cfg;
    logic              fix_flag;
    logic [CHAR_W-1:0] field_buf [RUN_CHARS];

    coord_rec_t coord_queue [$];

    logic [CHAR_W-1:0] lat_text [LAT_CHARS];
    logic [CHAR_W-1:0] lon_text [LON_CHARS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int chars_checked  = 0;
    int runs_seen      = 0;
    int mismatches     = 0;
    int stall_cycles;

    rmc_position_extractor #(
        .LAT_CHARS (LAT_CHARS),
        .LON_CHARS (LON_CHARS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coord_char   (coord_char),
        .is_longitude (is_longitude),
        .char_index   (char_index),
        .fix_valid    (fix_valid),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void reset_parser();
        parse_ph  = PH_HUNT;
        parse_pos = '0;
        skip_cfg  = SKIP_RESET;
        fix_flag  = 1'b0;
    endfunction

    // Advance the parser model by one accepted byte; queue a run on completion.
    function automatic void track_byte(input logic [CHAR_W-1:0] b);
        coord_rec_t rec;
        int         k;
        case (parse_ph)
            PH_HUNT:
            begin
                if (b == CH_DOLLAR)
                begin
                    parse_ph  = PH_HEADER;
                    parse_pos = '0;
                end
            end
            PH_HEADER:
            begin
                if (parse_pos < 5 && b == HDR_TEXT[CHAR_W*(4-parse_pos) +: CHAR_W])
                begin
                    parse_pos = parse_pos + 1'b1;
                    if (parse_pos == 5)
                    begin
                        parse_pos = '0;
                        if (skip_cfg == 0)
                            parse_ph = PH_STATUS;
                        else
                            parse_ph = PH_SKIP;
                    end
                end
                else
                    parse_ph = PH_HUNT;
            end
            PH_SKIP:
            begin
                parse_pos = parse_pos + 1'b1;
                if (parse_pos >= skip_cfg)
                    parse_ph = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (b == CH_A || b == CH_V)
                begin
                    fix_flag = (b == CH_A);
                    parse_ph = PH_GAP1;
                end
                else
                    parse_ph = PH_HUNT;
            end
            PH_GAP1:
            begin
                parse_pos = '0;
                parse_ph  = PH_LAT;
            end
            PH_LAT:
            begin
                field_buf[parse_pos] = b;
                parse_pos = parse_pos + 1'b1;
                if (parse_pos >= LAT_CHARS)
                    parse_ph = PH_GAP2;
            end
            PH_GAP2:
                parse_ph = PH_HEMI;
            PH_HEMI:
            begin
                if (b == CH_N)
                    parse_ph = PH_GAP3;
                else
                    parse_ph = PH_HUNT;
            end
            PH_GAP3:
            begin
                parse_pos = '0;
                parse_ph  = PH_LON;
            end
            PH_LON:
            begin
                field_buf[LAT_CHARS + parse_pos] = b;
                parse_pos = parse_pos + 1'b1;
                if (parse_pos >= LON_CHARS)
                begin
                    parse_ph  = PH_HUNT;
                    parse_pos = '0;
                    for (k = 0; k < RUN_CHARS; k++)
                    begin
                        rec.ch   = field_buf[k];
                        rec.lon  = (k >= LAT_CHARS);
                        rec.idx  = INDEX_W'((k >= LAT_CHARS) ? k - LAT_CHARS : k);
                        rec.fix  = fix_flag;
                        rec.last = (k == RUN_CHARS - 1);
                        coord_queue.push_back(rec);
                    end
                end
            end
            default:
                parse_ph = PH_HUNT;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] other_than(input logic [CHAR_W-1:0] x,
                                                     input logic [CHAR_W-1:0] y);
        logic [CHAR_W-1:0] pick;
        pick = CHAR_W'($urandom_range(255));
        while (pick == x || pick == y)
            pick = CHAR_W'($urandom_range(255));
        return pick;
    endfunction

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Receiver back-pressure
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_coords
        coord_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (coord_queue.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual char %0h",
                         $time, coord_char);
                mismatches++;
            end
            else
            begin
                want = coord_queue.pop_front();
                compare_field("coord_char",   int'(want.ch),   int'(coord_char));
                compare_field("is_longitude", int'(want.lon),  int'(is_longitude));
                compare_field("char_index",   int'(want.idx),  int'(char_index));
                compare_field("fix_valid",    int'(want.fix),  int'(fix_valid));
                compare_field("last",         int'(want.last), int'(last));
                chars_checked++;
                if (want.last)
                    runs_seen++;
            end
        end
    end

    // Count cycles with work pending and no transaction on either channel.
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                !(in_valid || coord_queue.size() != 0))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: watchdog expired, %0d characters still pending",
                 $time, coord_queue.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(input logic [CHAR_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait until every queued run has drained.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (coord_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip(input logic [SKIP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        skip_cfg    = value;
    endtask

    task automatic fill_fields();
        int i;
        for (i = 0; i < LAT_CHARS; i++)
            lat_text[i] = CHAR_W'($urandom_range(255));
        for (i = 0; i < LON_CHARS; i++)
            lon_text[i] = CHAR_W'($urandom_range(255));
    endtask

    // '$GPRMC' followed by n_skip time bytes; bad_at corrupts one header letter.
    task automatic send_head(input int n_skip, input int bad_at);
        logic [CHAR_W-1:0] ch;
        int                i;
        send_byte(CH_DOLLAR);
        for (i = 0; i < 5; i++)
        begin
            ch = HDR_TEXT[CHAR_W*(4-i) +: CHAR_W];
            if (i == bad_at)
                ch = other_than(ch, ch);
            send_byte(ch);
        end
        for (i = 0; i < n_skip; i++)
            send_byte(CHAR_W'($urandom_range(255)));
    endtask

    task automatic send_tail(input logic [CHAR_W-1:0] status_ch,
                             input logic [CHAR_W-1:0] hemi_ch);
        int i;
        send_byte(status_ch);
        send_byte(CHAR_W'($urandom_range(255)));
        for (i = 0; i < LAT_CHARS; i++)
            send_byte(lat_text[i]);
        send_byte(CHAR_W'($urandom_range(255)));
        send_byte(hemi_ch);
        send_byte(CHAR_W'($urandom_range(255)));
        for (i = 0; i < LON_CHARS; i++)
            send_byte(lon_text[i]);
    endtask

    task automatic test_default_skip();
        int i;
        for (i = 0; i < LAT_CHARS; i++)
            lat_text[i] = (i % 2) ? 8'hFF : 8'h00;
        for (i = 0; i < LON_CHARS; i++)
            lon_text[i] = (i % 2) ? 8'h00 : 8'hFF;
        send_head(int'(skip_cfg), -1);
        send_tail(CH_A, CH_N);
    endtask

    task automatic test_void_status();
        fill_fields();
        send_head(int'(skip_cfg), -1);
        send_tail(CH_V, CH_N);
    endtask

    // A '$' in place of 'G' aborts the hunt and is not looked at again,
    // so the sentence right behind it is lost.
    task automatic test_header_restart();
        fill_fields();
        send_byte(CH_DOLLAR);
        send_head(int'(skip_cfg), -1);
        send_tail(CH_A, CH_N);
    endtask

    // Stop after the bad status letter: the rest would only be noise.
    task automatic test_bad_status();
        send_head(int'(skip_cfg), -1);
        send_byte(other_than(CH_A, CH_V));
    endtask

    // Stop after the bad hemisphere letter: the rest would only be noise.
    task automatic test_bad_hemisphere();
        int i;
        fill_fields();
        send_head(int'(skip_cfg), -1);
        send_byte(CH_A);
        send_byte(CHAR_W'($urandom_range(255)));
        for (i = 0; i < LAT_CHARS; i++)
            send_byte(lat_text[i]);
        send_byte(CHAR_W'($urandom_range(255)));
        send_byte(other_than(CH_N, CH_N));
    endtask

    // A '$' inside the captured fields is plain data.
    task automatic test_dollar_in_fields();
        fill_fields();
        lat_text[0]             = CH_DOLLAR;
        lat_text[LAT_CHARS - 1] = CH_DOLLAR;
        lon_text[4]             = CH_DOLLAR;
        send_head(int'(skip_cfg), -1);
        send_tail(CH_V, CH_N);
    endtask

    task automatic test_zero_skip();
        settle();
        write_skip(5'd0);
        fill_fields();
        send_head(0, -1);
        send_tail(CH_A, CH_N);
    endtask

    task automatic test_max_skip();
        settle();
        write_skip(5'd31);
        fill_fields();
        send_head(31, -1);
        send_tail(CH_V, CH_N);
    endtask

    // Lower the skip count after five time bytes: the next byte still counts
    // as skipped, then the status letter is due.
    task automatic test_skip_change_mid();
        settle();
        write_skip(5'd12);
        fill_fields();
        send_head(5, -1);
        settle();
        write_skip(5'd3);
        send_byte(CHAR_W'($urandom_range(255)));
        send_tail(CH_A, CH_N);
    endtask

    task automatic run_traffic(input int n_bytes, input logic [SKIP_W-1:0] skip,
                               input int idle_pct, input int stall_pct);
        int stop_at;
        int pick;
        settle();
        write_skip(skip);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            fill_fields();
            if (pick < 68)
            begin
                send_head(int'(skip_cfg), -1);
                send_tail($urandom_range(1) ? CH_A : CH_V, CH_N);
            end
            else if (pick < 78)
            begin
                send_head(int'(skip_cfg), int'($urandom_range(4)));
                send_tail(CH_A, CH_N);
            end
            else if (pick < 85)
            begin
                send_head(int'(skip_cfg), -1);
                send_tail(other_than(CH_A, CH_V), CH_N);
            end
            else if (pick < 91)
            begin
                send_head(int'(skip_cfg), -1);
                send_tail(CH_V, other_than(CH_N, CH_N));
            end
            else if (pick < 95)
            begin
                // misaligned time field
                send_head(int'($urandom_range(31)), -1);
                send_tail(CH_A, CH_N);
            end
            else
                repeat ($urandom_range(1, 8)) send_byte(CHAR_W'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(30, SKIP_W'($urandom_range(1, 30)), 24, 24);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        reset_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // No idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_default_skip();
        test_header_restart();
        test_bad_status();

        // Sender idle
        send_idle_pct  = 55;
        recv_stall_pct = 0;
        test_max_skip();
        test_skip_change_mid();

        // Receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        test_zero_skip();
        test_void_status();
        test_dollar_in_fields();

        // Both
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        test_bad_hemisphere();
        test_random_traffic();

        settle();
        repeat (20) @(posedge clk);
        if (coord_queue.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time, coord_queue.size());
            mismatches++;
        end
        $display("Sent %0d bytes; checked %0d characters in %0d coordinate runs",
                 bytes_sent, chars_checked, runs_seen);
        $display("Skip counts 0, 3, 12, 31 and random; input gaps and output stalls mixed");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/rmc_pkg.sv
sv/rmc_front.sv
sv/rmc_fifo.sv
sv/rmc_back.sv
sv/rmc_position_extractor.sv
dv/tb_rmc_position_extractor.sv
